/* hw/rtl/shabsh_pkg.sv */
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package shabsh_pkg;

  localparam int WordW  = 32;
  localparam int ByteW  = 8;
  localparam int FillW  = 6;
  localparam int CountW = 61;
  localparam int RoundW = 6;
  localparam int IdxW   = 3;
  localparam int NumH   = 8;
  localparam int NumW   = 16;

  localparam logic [ByteW-1:0] PAD_MARK = 8'h80;
  localparam logic [FillW-1:0] LEN_POS  = 6'd56;

  localparam logic [WordW-1:0] HASH_IV [NumH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_EMIT
  } state_t;

  // source of the byte written into the block
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      wr;
    byte_sel_t sel;
    logic      load;
    logic      round;
    logic      fold;
    logic      emit_adv;
    logic      clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_last;   // next byte completes the block
    logic fill_hi;     // next byte lands in the length field
    logic round_last;
    logic emit_last;
  } dp_status_t;

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
    logic [WordW-1:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/shabsh_ctrl.sv */
// Control state machine: byte intake, padding sequence, compression and digest output.
`timescale 1ns / 1ps

module shabsh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   msg_valid,
  input  logic                   byte_valid,
  input  logic                   last_byte,
  input  logic                   dig_stall,
  input  shabsh_pkg::dp_status_t status,
  output logic                   msg_stall,
  output logic                   dig_valid,
  output shabsh_pkg::ctrl_cmd_t  cmd
);
  import shabsh_pkg::*;

  state_t state, state_next;
  logic   pend_last, pend_last_next;   // message closed, digest owed
  logic   marker, marker_next;         // 0x80 already written
  logic   need_extra, need_extra_next; // marker landed in the length field
  logic   len_done, len_done_next;     // length written, next fold is final

  logic   msg_acc;
  logic   dig_acc;

  assign msg_acc = msg_valid && (state == S_IDLE);
  assign dig_acc = (state == S_EMIT) && !dig_stall;

  // padding byte choice
  byte_sel_t pad_sel;
  always_comb begin
    if (!marker) begin
      pad_sel = SEL_MARK;
    end else if (status.fill_hi && !need_extra) begin
      pad_sel = SEL_LEN;
    end else begin
      pad_sel = SEL_ZERO;
    end
  end

  // next state and flags
  always_comb begin
    state_next      = state;
    pend_last_next  = pend_last;
    marker_next     = marker;
    need_extra_next = need_extra;
    len_done_next   = len_done;
    case (state)
      S_IDLE: begin
        if (msg_acc) begin
          pend_last_next = last_byte;
          if (byte_valid && status.fill_last) begin
            state_next = S_LOAD;
          end else if (last_byte) begin
            state_next = S_PAD;
          end
        end
      end
      S_LOAD: begin
        state_next = S_ROUND;
      end
      S_ROUND: begin
        if (status.round_last) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        need_extra_next = 1'b0;
        if (!pend_last) begin
          state_next = S_IDLE;
        end else if (len_done) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        if (!marker) begin
          marker_next     = 1'b1;
          need_extra_next = status.fill_hi;
        end else if ((pad_sel == SEL_LEN) && status.fill_last) begin
          len_done_next = 1'b1;
        end
        if (status.fill_last) begin
          state_next = S_LOAD;
        end
      end
      S_EMIT: begin
        if (dig_acc && status.emit_last) begin
          state_next      = S_IDLE;
          pend_last_next  = 1'b0;
          marker_next     = 1'b0;
          need_extra_next = 1'b0;
          len_done_next   = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_DATA;
    msg_stall = (state != S_IDLE);
    dig_valid = (state == S_EMIT);
    case (state)
      S_IDLE: begin
        cmd.wr = msg_acc && byte_valid;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
      end
      S_PAD: begin
        cmd.wr  = 1'b1;
        cmd.sel = pad_sel;
      end
      S_EMIT: begin
        cmd.emit_adv = dig_acc;
        cmd.clear    = dig_acc && status.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_last  <= 1'b0;
      marker     <= 1'b0;
      need_extra <= 1'b0;
      len_done   <= 1'b0;
    end else begin
      state      <= state_next;
      pend_last  <= pend_last_next;
      marker     <= marker_next;
      need_extra <= need_extra_next;
      len_done   <= len_done_next;
    end
  end

endmodule

/* hw/rtl/shabsh_dp.sv */
// Datapath: byte packing, message schedule window, round unit, hash words and output select.
`timescale 1ns / 1ps

module shabsh_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [shabsh_pkg::ByteW-1:0]    data_byte,
  input  shabsh_pkg::ctrl_cmd_t           cmd,
  output shabsh_pkg::dp_status_t          status,
  output logic [shabsh_pkg::WordW-1:0]    digest_word,
  output logic [shabsh_pkg::IdxW-1:0]     word_index,
  output logic                            last_word
);
  import shabsh_pkg::*;

  logic [FillW-1:0]  fill;
  logic [CountW-1:0] msg_count;
  logic [23:0]       pack;        // bytes of the word being assembled
  logic [WordW-1:0]  w_win [NumW]; // block words, then the rolling schedule
  logic [WordW-1:0]  wv [NumH];    // working variables a..h
  logic [WordW-1:0]  h [NumH];
  logic [RoundW-1:0] rnd;
  logic [IdxW-1:0]   idx;

  logic [63:0]       len_bits;
  logic [ByteW-1:0]  len_byte;
  logic [ByteW-1:0]  wr_byte;
  logic [WordW-1:0]  w_new;
  logic [WordW-1:0]  t1, t2;
  logic [WordW-1:0]  ch, maj;

  assign len_bits = {msg_count, 3'b000};
  assign len_byte = len_bits[{~fill[2:0], 3'b000} +: ByteW];

  always_comb begin
    case (cmd.sel)
      SEL_DATA: wr_byte = data_byte;
      SEL_MARK: wr_byte = PAD_MARK;
      SEL_ZERO: wr_byte = '0;
      SEL_LEN:  wr_byte = len_byte;
      default:  wr_byte = '0;
    endcase
  end

  assign w_new = small_sigma1(w_win[14]) + w_win[9] + small_sigma0(w_win[1]) + w_win[0];

  assign ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1  = wv[7] + big_sigma1(wv[4]) + ch + round_k(rnd) + w_win[0];
  assign t2  = big_sigma0(wv[0]) + maj;

  assign status.fill_last  = (fill == {FillW{1'b1}});
  assign status.fill_hi    = (fill >= LEN_POS);
  assign status.round_last = (rnd == {RoundW{1'b1}});
  assign status.emit_last  = (idx == {IdxW{1'b1}});

  assign digest_word = h[idx];
  assign word_index  = idx;
  assign last_word   = (idx == {IdxW{1'b1}});

  // control counters and hash state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill      <= '0;
      msg_count <= '0;
      rnd       <= '0;
      idx       <= '0;
      for (int i = 0; i < NumH; i++) begin
        h[i] <= HASH_IV[i];
      end
    end else begin
      if (cmd.wr) begin
        fill <= fill + 1'b1;
        if (cmd.sel == SEL_DATA) begin
          msg_count <= msg_count + 1'b1;
        end
      end
      if (cmd.load) begin
        rnd <= '0;
      end else if (cmd.round) begin
        rnd <= rnd + 1'b1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < NumH; i++) begin
          h[i] <= h[i] + wv[i];
        end
      end
      if (cmd.emit_adv) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // payload: byte packing, schedule window, working variables
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      if (fill[1:0] == 2'b11) begin
        for (int i = 0; i < NumW - 1; i++) begin
          w_win[i] <= w_win[i+1];
        end
        w_win[NumW-1] <= {pack, wr_byte};
      end else begin
        pack <= {pack[15:0], wr_byte};
      end
    end else if (cmd.round) begin
      for (int i = 0; i < NumW - 1; i++) begin
        w_win[i] <= w_win[i+1];
      end
      w_win[NumW-1] <= w_new;
    end
    if (cmd.load) begin
      for (int i = 0; i < NumH; i++) begin
        wv[i] <= h[i];
      end
    end else if (cmd.round) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

endmodule

/* hw/rtl/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher: controller plus datapath.
`timescale 1ns / 1ps

// Usage
//   Message channel (msg_valid / msg_stall): one word per handshake carries
//   data_byte, byte_valid and last_byte. last_byte closes the message; with
//   byte_valid low it adds no byte, so an empty message is one such word.
//   Digest channel (dig_valid / dig_stall): eight words per message,
//   digest_word with word_index 0..7, most significant first, last_word on 7.
// Timing
//   A message word is accepted while the block buffer has room. The 64th
//   byte of a block starts a compression (load, 64 rounds on one shared
//   round unit, fold), during which msg_stall stays high.
//   After last_byte the pad sequencer writes one byte per cycle (0x80, zeros,
//   8 length bytes) up to the end of the block and compresses it, padding and
//   compressing one more block when 56 or more bytes were held. The digest
//   words follow, one per cycle when not stalled.
// Stall and reset
//   dig_stall holds the current digest word; no new message word is taken
//   until all eight are delivered, then the hash state returns to the initial
//   values. rst is synchronous and clears the controller, counters and hash.

module sha256_byte_stream_hasher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         msg_valid,
  output logic                         msg_stall,
  input  logic [shabsh_pkg::ByteW-1:0] data_byte,
  input  logic                         byte_valid,
  input  logic                         last_byte,
  output logic                         dig_valid,
  input  logic                         dig_stall,
  output logic [shabsh_pkg::WordW-1:0] digest_word,
  output logic [shabsh_pkg::IdxW-1:0]  word_index,
  output logic                         last_word
);
  import shabsh_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  shabsh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .byte_valid (byte_valid),
    .last_byte  (last_byte),
    .dig_stall  (dig_stall),
    .status     (status),
    .msg_stall  (msg_stall),
    .dig_valid  (dig_valid),
    .cmd        (cmd)
  );

  shabsh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

/* verif/sha256_digest_sb_pkg.sv */
// Digest scoreboard: SHA-256 predictor and in-order checker for the digest words.
`timescale 1ns / 1ps

package sha256_digest_sb_pkg;

  import shabsh_pkg::WordW;
  import shabsh_pkg::ByteW;
  import shabsh_pkg::IdxW;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [IdxW-1:0]  index;
    logic             last;
  } digest_exp_t;

  localparam logic [WordW-1:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [ByteW-1:0] END_MARK  = 8'h80;
  localparam int               LEN_START = 56;

  class sha256_digest_sb;
    logic [WordW-1:0] chain [8];
    logic [ByteW-1:0] blk [64];
    int unsigned      fill;
    logic [60:0]      msg_len;
    digest_exp_t      digest_q [$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = START_HASH[i];
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
      msg_len = '0;
    endfunction

    function logic [WordW-1:0] rotr(logic [WordW-1:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk into chain
    function void compress();
      logic [WordW-1:0] w [64];
      logic [WordW-1:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int i = 0; i < 64; i++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_CONST[i] + w[i];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // accepted message word; a closing word queues the eight digest words
    function void note_word(logic [ByteW-1:0] data, logic has_byte, logic closes);
      logic [63:0] bit_len;
      if (has_byte) begin
        blk[fill] = data;
        fill++;
        msg_len++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!closes) return;
      bit_len = {msg_len, 3'b000};
      blk[fill] = END_MARK;
      fill++;
      if (fill > LEN_START) begin
        for (int i = fill; i < 64; i++) blk[i] = '0;
        compress();
        fill = 0;
      end
      for (int i = fill; i < LEN_START; i++) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++)
        digest_q.push_back(digest_exp_t'{word: chain[i], index: IdxW'(i), last: (i == 7)});
      restart();
    endfunction

    function void check_digest(logic [WordW-1:0] word, logic [IdxW-1:0] index, logic last);
      digest_exp_t exp_w;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h index %0d last %0b", word, index, last);
        return;
      end
      exp_w = digest_q.pop_front();
      if (word !== exp_w.word || index !== exp_w.index || last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: exp word %h index %0d last %0b, got %h %0d %0b",
                   exp_w.word, exp_w.index, exp_w.last, word, index, last);
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

endpackage

/* verif/sha256_byte_stream_hasher_tb.sv */
// Testbench of the SHA-256 byte stream hasher: random messages checked against a predictor.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;

  import shabsh_pkg::*;
  import sha256_digest_sb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 40;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             msg_valid = 1'b0;
  logic             msg_stall;
  logic [ByteW-1:0] data_byte = '0;
  logic             byte_valid = 1'b0;
  logic             last_byte = 1'b0;
  logic             dig_valid;
  logic             dig_stall = 1'b0;
  logic [WordW-1:0] digest_word;
  logic [IdxW-1:0]  word_index;
  logic             last_word;

  // idle odds in percent per cycle, changed per phase
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 65;
  int unsigned words_sent = 0;   // words that carry a byte or close a message
  int unsigned cycles = 0;

  sha256_digest_sb sb;

  sha256_byte_stream_hasher u_dut (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .last_byte   (last_byte),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  always #6 clk = ~clk;

  // Watchdog: budget covers every compression, padding pass and stalled digest many times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // digest side backpressure, new draw every cycle
  always @(negedge clk) begin
    dig_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // digest monitor: a word moves when valid is high and stall is low at the edge
  always @(posedge clk) begin
    if (!rst && dig_valid && !dig_stall)
      sb.check_digest(digest_word, word_index, last_word);
  end

  // Drive one message word. Entered and left at a falling edge, so valid gets at
  // most one update per time step and stays high across back-to-back words.
  task automatic send_word(logic [ByteW-1:0] data, logic has_byte, logic closes);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    msg_valid  <= 1'b1;
    data_byte  <= data;
    byte_valid <= has_byte;
    last_byte  <= closes;
    do @(posedge clk); while (msg_stall);
    sb.note_word(data, has_byte, closes);
    if (has_byte || closes) words_sent++;
    @(negedge clk);
  endtask

  // Random message of len bytes. The close either rides on the final byte or
  // comes as a separate word with no byte; stray idle words sprinkle in.
  task automatic send_message(int len);
    logic close_on_byte;
    close_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(ByteW'($urandom), 1'b0, 1'b0);
      send_word(ByteW'($urandom), 1'b1, close_on_byte && (k == len - 1));
    end
    if (!close_on_byte)
      send_word(ByteW'($urandom), 1'b0, 1'b1);
  endtask

  // Length mix: mostly short, a fair share right at the padding boundaries
  // (55/56/57 held bytes and full blocks), a few spanning two blocks.
  function automatic int pick_len();
    int unsigned r;
    int          edge_lens [6] = '{55, 56, 57, 63, 64, 65};
    r = $urandom_range(0, 99);
    if (r < 30) return edge_lens[$urandom_range(0, 5)];
    if (r < 35) return $urandom_range(100, 130);
    return $urandom_range(0, 24);
  endfunction

  initial begin
    sb = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty message, idle word, single byte extremes, "abc",
    // bytes closed by an empty word, and an empty close with junk data
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'ha5, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h5a, 1'b1, 1'b0);
    send_word(8'hc3, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b1);

    // phase 1: sender idles rarely, receiver often
    while (words_sent < 45) send_message(pick_len());
    // phase 2: roles swapped
    send_idle_pct = 65;
    recv_idle_pct = 19;
    while (words_sent < 85) send_message(pick_len());
    // phase 3: full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_sent < 120) send_message(pick_len());
    msg_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
